// ----- sv/pf_enc_pkg.sv -----
// Shared types, constants and helper functions for the Playfair digraph encryptor.
`timescale 1ns / 1ps

package pf_enc_pkg;

	// Square geometry and letter coding
	localparam int SQUARE_SIDE  = 5;
	localparam int CELL_COUNT   = SQUARE_SIDE * SQUARE_SIDE;
	localparam int LETTER_COUNT = 26;
	localparam int LETTER_W     = 5;
	localparam int POS_W        = $clog2(CELL_COUNT);
	localparam int FILL_W       = $clog2(CELL_COUNT + 1);
	localparam int COORD_W      = $clog2(SQUARE_SIDE);

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [FILL_W-1:0]   fill_t;
	typedef logic [COORD_W-1:0]  coord_t;

	localparam letter_t LETTER_I    = letter_t'(8);
	localparam letter_t LETTER_J    = letter_t'(9);
	localparam letter_t LETTER_LAST = letter_t'(LETTER_COUNT - 1);

	// Request codes carried in req_type
	typedef enum logic [1:0] {
		REQ_KEY     = 2'd0,
		REQ_FINISH  = 2'd1,
		REQ_ENCRYPT = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_FILL,
		ST_CLEAR,
		ST_LOOK,
		ST_MAP,
		ST_EMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic key_place;
		logic fill_step;
		logic clear;
		logic look;
		logic map;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic ready;
		logic walk_last;
		logic out_free;
	} dp_stat_t;

	// A j in a plaintext pair is looked up as i.
	function automatic letter_t fold_letter(input letter_t l);
		return (l == LETTER_J) ? LETTER_I : l;
	endfunction

	// Row of a cell position, found by comparing against the row starts.
	function automatic coord_t pos_row(input pos_t pos);
		coord_t row;
		row = '0;
		for (int r = 0; r < SQUARE_SIDE; r++) begin
			if (pos >= pos_t'(r * SQUARE_SIDE)) begin
				row = coord_t'(r);
			end
		end
		return row;
	endfunction

	// Column of a cell position.
	function automatic coord_t pos_col(input pos_t pos);
		pos_t base;
		base = pos_t'(pos_row(pos) * SQUARE_SIDE);
		return coord_t'(pos - base);
	endfunction

	// Next row or column index, wrapping at the square edge.
	function automatic coord_t next_coord(input coord_t c);
		return (c == coord_t'(SQUARE_SIDE - 1)) ? '0 : coord_t'(c + coord_t'(1));
	endfunction

	// Cell position from row and column.
	function automatic pos_t cell_at(input coord_t row, input coord_t col);
		return pos_t'(row * SQUARE_SIDE + col);
	endfunction

endpackage

// ----- sv/pf_enc_dp.sv -----
// Datapath: key square memories, letter bookkeeping, cipher mapping and output register.
`timescale 1ns / 1ps

module pf_enc_dp import pf_enc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  letter_t  first_letter,
	input  letter_t  second_letter,
	output letter_t  cipher_first,
	output letter_t  cipher_second,
	output logic     status,
	output logic     out_valid,
	input  logic     out_stall
);

	letter_t a_q, b_q;
	logic [LETTER_COUNT-1:0] seen_q;
	fill_t   fill_q;
	logic    ready_q;
	letter_t walk_q;

	letter_t cell_mem [CELL_COUNT];
	pos_t    pos_mem  [LETTER_COUNT];

	pos_t    pa_s1, pb_s1;
	logic    a_big_s1, b_big_s1;
	letter_t cell_a_s2, cell_b_s2;

	letter_t first_q, second_q;
	logic    status_q, out_valid_q;

	// Capture the incoming word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= first_letter;
			b_q <= second_letter;
		end
	end

	// Placement of a key letter or of the next letter in the alphabet walk
	letter_t wr_letter;
	logic    in_range, seen_hit, wr_en;

	always_comb begin
		wr_letter = cmd.fill_step ? walk_q : a_q;
		in_range  = (wr_letter <= LETTER_LAST);
		seen_hit  = in_range ? seen_q[wr_letter] : 1'b1;
		wr_en     = (cmd.key_place || cmd.fill_step) && !ready_q && in_range
			&& (wr_letter != LETTER_J) && !seen_hit && (fill_q < fill_t'(CELL_COUNT));
	end

	// Letter bookkeeping and fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			fill_q  <= '0;
			ready_q <= 1'b0;
			walk_q  <= '0;
		end else if (cmd.clear) begin
			seen_q  <= '0;
			fill_q  <= '0;
			ready_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				walk_q <= '0;
			end else if (cmd.fill_step) begin
				walk_q <= letter_t'(walk_q + letter_t'(1));
			end
			if (wr_en) begin
				seen_q[wr_letter] <= 1'b1;
				fill_q <= fill_t'(fill_q + fill_t'(1));
			end
			if (cmd.fill_step && (walk_q == LETTER_LAST)) begin
				ready_q <= 1'b1;
			end
		end
	end

	// Square cells and the letter-to-position table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cell_mem[fill_q[POS_W-1:0]] <= wr_letter;
			pos_mem[wr_letter] <= fill_q[POS_W-1:0];
		end
	end

	// Position lookup of both plaintext letters
	letter_t fold_a, fold_b;
	logic    a_big, b_big;

	always_comb begin
		fold_a = fold_letter(a_q);
		fold_b = fold_letter(b_q);
		a_big  = (fold_a > LETTER_LAST);
		b_big  = (fold_b > LETTER_LAST);
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			pa_s1    <= pos_mem[a_big ? letter_t'(0) : fold_a];
			pb_s1    <= pos_mem[b_big ? letter_t'(0) : fold_b];
			a_big_s1 <= a_big;
			b_big_s1 <= b_big;
		end
	end

	// Cipher rules on row and column, then read both cipher cells
	pos_t   pa, pb, oa, ob;
	coord_t ra, ca, rb, cb;

	always_comb begin
		pa = a_big_s1 ? '0 : pa_s1;
		pb = b_big_s1 ? '0 : pb_s1;
		ra = pos_row(pa);
		ca = pos_col(pa);
		rb = pos_row(pb);
		cb = pos_col(pb);
		if (ra == rb) begin
			oa = cell_at(ra, next_coord(ca));
			ob = cell_at(rb, next_coord(cb));
		end else if (ca == cb) begin
			oa = cell_at(next_coord(ra), ca);
			ob = cell_at(next_coord(rb), cb);
		end else begin
			oa = cell_at(ra, cb);
			ob = cell_at(rb, ca);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			cell_a_s2 <= cell_mem[oa];
			cell_b_s2 <= cell_mem[ob];
		end
	end

	// Output register; an unfinished square echoes the letters with status set
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			first_q  <= ready_q ? cell_a_s2 : a_q;
			second_q <= ready_q ? cell_b_s2 : b_q;
			status_q <= !ready_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cipher_first   = first_q;
	assign cipher_second  = second_q;
	assign status         = status_q;
	assign out_valid      = out_valid_q;

	assign stat.ready     = ready_q;
	assign stat.walk_last = (walk_q == LETTER_LAST);
	assign stat.out_free  = !out_valid_q || !out_stall;

	// Every placed letter is marked seen exactly once.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(seen_q) == int'(fill_q))
		else $error("seen letter count differs from fill position");

	// A finished square has every cell written.
	assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (fill_q == fill_t'(CELL_COUNT)))
		else $error("square ready with cells left empty");

	// The letter j never enters the square.
	assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q[LETTER_J])
		else $error("letter j placed in the square");

endmodule

// ----- sv/pf_enc_ctrl.sv -----
// Controller: sequences key placement, the finish walk, clearing and encryption.
`timescale 1ns / 1ps

module pf_enc_ctrl import pf_enc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (req_t'(req_type))
						REQ_KEY:     state_d = ST_KEY;
						REQ_FINISH:  state_d = stat.ready ? ST_IDLE : ST_FILL;
						REQ_ENCRYPT: state_d = ST_LOOK;
						REQ_CLEAR:   state_d = ST_CLEAR;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_KEY:   state_d = ST_IDLE;
			ST_CLEAR: state_d = ST_IDLE;
			ST_FILL: begin
				if (stat.walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOOK:  state_d = ST_MAP;
			ST_MAP:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands and handshake
	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:  cmd.load      = in_valid;
			ST_KEY:   cmd.key_place = 1'b1;
			ST_FILL:  cmd.fill_step = 1'b1;
			ST_CLEAR: cmd.clear     = 1'b1;
			ST_LOOK:  cmd.look      = 1'b1;
			ST_MAP:   cmd.map       = 1'b1;
			ST_EMIT:  cmd.emit      = stat.out_free;
			default:  cmd = '0;
		endcase
	end

	// The finish walk only runs on a square that is still open.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> !stat.ready)
		else $error("finish walk on a ready square");

endmodule

// ----- sv/playfair_digraph_encryptor_top.sv -----
// Top level of the Playfair digraph encryptor: controller plus datapath.
`timescale 1ns / 1ps

// Builds a 5x5 Playfair key square from key-letter words, completes it on a
// finish word and then encrypts letter pairs (j is taken as i). Input words
// are taken one at a time: a key letter or a clear passes through its own
// state, a finish on an open square runs the alphabet walk, which steps
// through one letter per cycle, and an encrypt passes two registered reads in a
// row (letter positions, then cipher cells). A result sits in an output
// register, so the next word is taken while it waits; an encrypt that finds
// that register still full waits in its last step. An encrypt before the
// square is finished echoes its letters with status 1.
module playfair_digraph_encryptor_top import pf_enc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  letter_t    first_letter,
	input  letter_t    second_letter,
	output logic       out_valid,
	input  logic       out_stall,
	output letter_t    cipher_first,
	output letter_t    cipher_second,
	output logic       status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pf_enc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	pf_enc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.first_letter  (first_letter),
		.second_letter (second_letter),
		.cipher_first  (cipher_first),
		.cipher_second (cipher_second),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

endmodule
